FILE: sv/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types and constants for the ipv4 header checksum insertion block.
// ----------------------------------------------------------------------------
package ihc_pkg;

	localparam int unsigned LANES      = 4;
	localparam int unsigned DATA_W     = 64;
	localparam int unsigned KEEP_W     = 8;
	localparam int unsigned WORD_W     = 16;

	localparam logic [3:0]  IHL_MIN    = 4'd5;
	localparam logic [2:0]  CHUNK_HEAD = 3'd0;  // chunk that carries ihl
	localparam logic [2:0]  CHUNK_CSUM = 3'd1;  // chunk that carries the checksum
	localparam logic [2:0]  CHUNK_SAT  = 3'd7;
	localparam logic [15:0] ONES_MASK  = 16'hFFFF;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [LANES-1:0] word_vec_t;

	typedef struct packed {
		logic [KEEP_W-1:0] keep;
		logic [DATA_W-1:0] data;
	} chunk_t;

endpackage

FILE: sv/ipv4_header_checksum_insert.sv
// ----------------------------------------------------------------------------
// ipv4_header_checksum_insert
// Holds the ipv4 header chunks of a packet, sums the header in four parallel
// lanes and releases the run, with the checksum in chunk 1 when the header is complete.
// ----------------------------------------------------------------------------
// header chunks are taken one per cycle while the output is not stalled and
// held until the header ends; the held run (n chunks, up to 8) then leaves one
// chunk per cycle while the output takes it, the first presented once drain_q
// and then the output register are set; no request is taken during the release.
// payload chunks after the header pass through the output register, one per
// cycle while the output is not stalled. reset clears all control state and the
// output valid; the chunk store is not cleared, only written entries are ever read.
module ipv4_header_checksum_insert #(
	parameter int unsigned HEADER_CHUNKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // in_data [63:0], in_keep [71:64]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // out_data [63:0], out_keep [71:64]
	output logic        m_tlast,
	output logic [0:0]  m_tuser    // run_end [0]
);

	localparam int unsigned CNT_W = $clog2(HEADER_CHUNKS + 1);
	localparam int unsigned PTR_W = $clog2(HEADER_CHUNKS);

	// packet state
	logic                 hdr_done_q;
	logic [3:0]           words_left_q;
	logic [2:0]           chunk_idx_q;
	ihc_pkg::word_t       psum_q;
	logic [CNT_W-1:0]     held_cnt_q;

	// run release
	logic                 drain_q;
	logic [PTR_W-1:0]     drain_ptr_q;
	logic [CNT_W-1:0]     drain_n_q;
	logic                 patch_q;
	logic                 last_q;
	ihc_pkg::word_t       csum_q;

	// output register
	logic                 out_valid_q;
	ihc_pkg::chunk_t      out_chunk_q;
	logic                 out_last_q;
	logic                 out_end_q;

	// chunk store
	ihc_pkg::chunk_t      held_mem [HEADER_CHUNKS];

	ihc_pkg::chunk_t      in_chunk;
	logic                 in_req;
	logic                 out_free;
	logic                 out_load;
	logic                 idx_first;
	logic [3:0]           ihl_eff;
	logic [3:0]           wl_cur;
	logic [3:0]           wl_next;
	ihc_pkg::word_t       ps_cur;
	ihc_pkg::word_t       ps_next;
	logic [CNT_W-1:0]     hc_cur;
	logic                 hc_store;
	logic [CNT_W-1:0]     hc_next;
	logic [ihc_pkg::LANES-1:0] lane_en;
	ihc_pkg::word_vec_t   lane_word;
	logic                 drain_final;
	logic                 drain_patch;

	assign in_chunk = ihc_pkg::chunk_t'(s_tdata);
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !drain_q && out_free;
	assign in_req   = s_tvalid && s_tready;
	assign out_load = (drain_q && out_free) || (in_req && hdr_done_q);

	always_comb begin
		idx_first = (chunk_idx_q == ihc_pkg::CHUNK_HEAD);
		ihl_eff   = (in_chunk.data[3:0] < ihc_pkg::IHL_MIN) ? ihc_pkg::IHL_MIN
		            : in_chunk.data[3:0];
		wl_cur    = idx_first ? ihl_eff : words_left_q;
		ps_cur    = idx_first ? '0 : psum_q;
		hc_cur    = idx_first ? '0 : held_cnt_q;
		wl_next   = (wl_cur >= 4'd2) ? wl_cur - 4'd2 : 4'd0;
		hc_store  = (hc_cur < CNT_W'(HEADER_CHUNKS));
		hc_next   = hc_store ? hc_cur + CNT_W'(1) : hc_cur;
		// bytes 10-11 of the header sit in lane 1 of chunk 1
		lane_en[0] = 1'b1;
		lane_en[1] = (chunk_idx_q != ihc_pkg::CHUNK_CSUM);
		lane_en[2] = (wl_cur >= 4'd2);
		lane_en[3] = (wl_cur >= 4'd2);
	end

	for (genvar g = 0; g < ihc_pkg::LANES; g++) begin : g_lane
		ihc_lane u_lane (
			.slice (in_chunk.data[g*ihc_pkg::WORD_W +: ihc_pkg::WORD_W]),
			.en    (lane_en[g]),
			.word  (lane_word[g])
		);
	end

	ihc_merge u_merge (
		.psum  (ps_cur),
		.words (lane_word),
		.sum   (ps_next)
	);

	always_comb begin
		drain_final = (CNT_W'(drain_ptr_q) + CNT_W'(1)) == drain_n_q;
		drain_patch = patch_q && (drain_ptr_q == PTR_W'(ihc_pkg::CHUNK_CSUM));
	end

	always_ff @(posedge clk) begin
		if (in_req && !hdr_done_q && hc_store) begin
			held_mem[hc_cur[PTR_W-1:0]] <= in_chunk;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_q && out_free) begin
			out_chunk_q.keep <= held_mem[drain_ptr_q].keep;
			if (drain_patch) begin
				out_chunk_q.data <= {held_mem[drain_ptr_q].data[ihc_pkg::DATA_W-1:32],
				                     csum_q[7:0], csum_q[15:8],
				                     held_mem[drain_ptr_q].data[15:0]};
			end else begin
				out_chunk_q.data <= held_mem[drain_ptr_q].data;
			end
			out_last_q  <= drain_final ? last_q : 1'b0;
			out_end_q   <= drain_final;
		end else if (in_req && hdr_done_q) begin
			out_chunk_q <= in_chunk;
			out_last_q  <= s_tlast;
			out_end_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_done_q   <= 1'b0;
			words_left_q <= '0;
			chunk_idx_q  <= '0;
			psum_q       <= '0;
			held_cnt_q   <= '0;
			drain_q      <= 1'b0;
			drain_ptr_q  <= '0;
			drain_n_q    <= '0;
			patch_q      <= 1'b0;
			last_q       <= 1'b0;
			csum_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= out_load;
			end
			if (drain_q && out_free) begin
				drain_ptr_q <= drain_ptr_q + PTR_W'(1);
				if (drain_final) begin
					drain_q <= 1'b0;
				end
			end else if (in_req) begin
				if (hdr_done_q) begin
					if (s_tlast) begin
						hdr_done_q   <= 1'b0;
						words_left_q <= '0;
						chunk_idx_q  <= '0;
						psum_q       <= '0;
						held_cnt_q   <= '0;
					end
				end else if (wl_next == 4'd0 || s_tlast) begin
					// release the run; checksum only when the header is complete
					drain_q      <= 1'b1;
					drain_ptr_q  <= '0;
					drain_n_q    <= hc_next;
					patch_q      <= (wl_next == 4'd0);
					last_q       <= s_tlast;
					csum_q       <= ~ps_next;
					hdr_done_q   <= !s_tlast;
					held_cnt_q   <= '0;
					if (s_tlast) begin
						words_left_q <= '0;
						chunk_idx_q  <= '0;
						psum_q       <= '0;
					end else begin
						words_left_q <= wl_next;
						chunk_idx_q  <= (chunk_idx_q < ihc_pkg::CHUNK_SAT)
						                ? chunk_idx_q + 3'd1 : ihc_pkg::CHUNK_SAT;
						psum_q       <= ps_next;
					end
				end else begin
					words_left_q <= wl_next;
					chunk_idx_q  <= (chunk_idx_q < ihc_pkg::CHUNK_SAT)
					                ? chunk_idx_q + 3'd1 : ihc_pkg::CHUNK_SAT;
					psum_q       <= ps_next;
					held_cnt_q   <= hc_next;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 72'(out_chunk_q);
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_end_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q <= CNT_W'(HEADER_CHUNKS))
		else $error("held chunk count beyond store depth");

	a_drain_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> (CNT_W'(drain_ptr_q) < drain_n_q))
		else $error("release pointer past end of run");

	a_pass_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_req && hdr_done_q) |=> (m_tvalid && m_tuser[0]))
		else $error("payload chunk not presented as a single-result run");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_q && out_free && drain_final) |=> (m_tvalid && m_tuser[0] && !drain_q))
		else $error("run release did not close with run end");

endmodule

FILE: sv/ihc_lane.sv
// ----------------------------------------------------------------------------
// ihc_lane
// One summing lane: turns a little-endian byte pair of the chunk into a
// big-endian header word, or zero when the word is not part of the sum.
// ----------------------------------------------------------------------------
module ihc_lane (
	input  logic [ihc_pkg::WORD_W-1:0] slice,
	input  logic                       en,
	output ihc_pkg::word_t             word
);

	// byte 2k is the high byte of the header word
	always_comb begin
		if (en) begin
			word = {slice[7:0], slice[15:8]};
		end else begin
			word = '0;
		end
	end

endmodule

FILE: sv/ihc_merge.sv
// ----------------------------------------------------------------------------
// ihc_merge
// Combines the lane words with the running sum in ones'-complement
// arithmetic with end-around carry.
// ----------------------------------------------------------------------------
module ihc_merge (
	input  ihc_pkg::word_t    psum,
	input  ihc_pkg::word_vec_t words,
	output ihc_pkg::word_t    sum
);

	logic [18:0] total;
	logic [16:0] fold1;
	logic [16:0] fold2;

	always_comb begin
		total = 19'(psum);
		for (int i = 0; i < ihc_pkg::LANES; i++) begin
			total = total + 19'(words[i]);
		end
		// two folds bring a five-term sum back to 16 bits
		fold1 = 17'(total[15:0]) + 17'(total[18:16]);
		fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
		sum   = fold2[15:0] & ihc_pkg::ONES_MASK;
	end

endmodule

FILE: verif/ihc_stream_checker.sv
// ----------------------------------------------------------------------------
// ihc_stream_checker
// Watches both stream channels of the ipv4 header checksum insertion block,
// predicts every outgoing chunk from the accepted requests and compares them.
// ----------------------------------------------------------------------------
module ihc_stream_checker #(
	parameter int unsigned HEADER_CHUNKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,   // in_data [63:0], in_keep [71:64]
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // out_data [63:0], out_keep [71:64]
	input  logic        m_tlast,
	input  logic [0:0]  m_tuser,   // run_end [0]
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [ihc_pkg::DATA_W-1:0] data;
		logic [ihc_pkg::KEEP_W-1:0] keep;
		logic                       last;
		logic                       run_end;
	} out_chunk_t;

	out_chunk_t                 due_chunks[$];
	logic [15:0]                hdr_sum;
	logic [3:0]                 words_todo;
	logic [2:0]                 chunk_idx;
	logic                       hdr_sent;
	logic [ihc_pkg::DATA_W-1:0] held_data [HEADER_CHUNKS];
	logic [ihc_pkg::KEEP_W-1:0] held_keep [HEADER_CHUNKS];
	int                         held_n;

	initial errors = 0;
	initial pending = 0;

	function automatic void restart_packet();
		hdr_sum    = '0;
		words_todo = '0;
		chunk_idx  = ihc_pkg::CHUNK_HEAD;
		hdr_sent   = 1'b0;
		held_n     = 0;
	endfunction

	function automatic void release_held(input logic patch, input logic last);
		out_chunk_t  o;
		logic [15:0] csum;
		csum = ~hdr_sum & ihc_pkg::ONES_MASK;
		for (int i = 0; i < held_n; i++) begin
			o.data = held_data[i];
			o.keep = held_keep[i];
			// byte 10 takes the high byte, byte 11 the low byte
			if (patch && i == ihc_pkg::CHUNK_CSUM)
				o.data[31:16] = {csum[7:0], csum[15:8]};
			o.last    = (i == held_n - 1) ? last : 1'b0;
			o.run_end = (i == held_n - 1);
			due_chunks.push_back(o);
		end
	endfunction

	function automatic void insert_checksum(input ihc_pkg::chunk_t c, input logic last);
		logic [2:0]  idx;
		logic [3:0]  ihl;
		logic [16:0] acc;
		int          lanes;
		out_chunk_t  o;
		idx = chunk_idx;
		if (hdr_sent) begin
			o.data    = c.data;
			o.keep    = c.keep;
			o.last    = last;
			o.run_end = 1'b1;
			due_chunks.push_back(o);
			if (last)
				restart_packet();
			return;
		end
		if (idx == ihc_pkg::CHUNK_HEAD) begin
			ihl        = (c.data[3:0] < ihc_pkg::IHL_MIN) ? ihc_pkg::IHL_MIN : c.data[3:0];
			words_todo = ihl;
			hdr_sum    = '0;
			held_n     = 0;
		end
		// with one 32-bit word left only bytes 0-3 belong to the header
		lanes = (words_todo >= 2) ? ihc_pkg::LANES : ihc_pkg::LANES / 2;
		for (int w = 0; w < lanes; w++) begin
			// bytes 10-11 are the checksum field itself
			if (!(idx == ihc_pkg::CHUNK_CSUM && w == 1)) begin
				acc     = hdr_sum + {c.data[16*w +: 8], c.data[16*w+8 +: 8]};
				hdr_sum = acc[15:0] + acc[16];
			end
		end
		words_todo = (words_todo >= 2) ? words_todo - 4'd2 : 4'd0;
		if (held_n < HEADER_CHUNKS) begin
			held_data[held_n] = c.data;
			held_keep[held_n] = c.keep;
			held_n++;
		end
		chunk_idx = (idx < ihc_pkg::CHUNK_SAT) ? idx + 3'd1 : ihc_pkg::CHUNK_SAT;
		if (words_todo == 0) begin
			release_held(1'b1, last);
			held_n   = 0;
			hdr_sent = 1'b1;
			if (last)
				restart_packet();
		end else if (last) begin
			// packet ended inside the header: run leaves untouched
			release_held(1'b0, last);
			restart_packet();
		end
	endfunction

	function automatic void check_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ihc_pkg::chunk_t got;
		out_chunk_t      want;
		if (!arst_n) begin
			restart_packet();
			due_chunks.delete();
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				insert_checksum(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (due_chunks.size() == 0) begin
					errors++;
					$display("%0t: unexpected chunk, expected none, got %h", $time, m_tdata);
				end else begin
					want = due_chunks.pop_front();
					check_field("out_data", want.data, got.data);
					check_field("out_keep", 64'(want.keep), 64'(got.keep));
					check_field("out_last", 64'(want.last), 64'(m_tlast));
					check_field("run_end", 64'(want.run_end), 64'(m_tuser[0]));
				end
			end
			pending = due_chunks.size();
		end
	end

endmodule

FILE: verif/tb_ipv4_header_checksum_insert.sv
// ----------------------------------------------------------------------------
// tb_ipv4_header_checksum_insert
// Drives ipv4 packets through the checksum insertion block: directed header
// shapes first, then random packets under several idle and stall patterns,
// one of them a long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_ipv4_header_checksum_insert;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 29;
	localparam int TAIL_CYCLES = 20;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
	typedef enum {PH_STEADY, PH_TX_IDLE, PH_RX_STALL, PH_BOTH, PH_BACKPRESSURE} phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;    // in_data [63:0], in_keep [71:64]
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;         // out_data [63:0], out_keep [71:64]
	logic        m_tlast;
	logic [0:0]  m_tuser;         // run_end [0]

	int   errors;
	int   pending;
	int   items_sent = 0;
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ipv4_header_checksum_insert #(
		.HEADER_CHUNKS(8)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	ihc_stream_checker #(
		.HEADER_CHUNKS(8)
	) u_csum_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.errors(errors),
		.pending(pending)
	);

	// output side: random stalls, plus one long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					m_tready <= 1'b0;
					@(posedge clk);
				end
				hold_done = 1'b1;
			end
			m_tready <= ($urandom_range(99) < rx_stall_pct) ? 1'b0 : 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("ipv4_header_checksum_insert test failed");
				$finish;
			end
		end
	end

	task automatic send_chunk(input logic [63:0] data, input logic [7:0] keep,
		input logic last);
		logic hs;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {keep, data};
		s_tlast  <= last;
		// ready is settled by the falling edge, so the request fate is known there
		do begin
			@(negedge clk);
			hs = s_tready;
			@(posedge clk);
		end while (!hs);
		items_sent++;
	endtask

	task automatic send_packet(input logic [3:0] ihl, input int nchunks, input fill_t fill);
		logic [63:0] d;
		logic [7:0]  k;
		for (int i = 0; i < nchunks; i++) begin
			case (fill)
				FILL_ZERO: begin
					d = '0;
					k = '0;
				end
				FILL_ONES: begin
					d = '1;
					k = '1;
				end
				default: begin
					d = {$urandom, $urandom};
					k = 8'($urandom);
				end
			endcase
			if (i == 0)
				d[3:0] = ihl;
			send_chunk(d, k, i == nchunks - 1);
		end
	endtask

	initial begin
		logic [3:0] ihl;
		int         hdr;
		int         n;
		int         pick;
		int         target;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_packet(4'd5, 4, FILL_RANDOM);   // minimal header plus a payload chunk
		send_packet(4'd15, 8, FILL_ONES);    // longest header, last on its end
		send_packet(4'd0, 4, FILL_ZERO);     // short ihl read as 5
		send_packet(4'd6, 2, FILL_RANDOM);   // last arrives inside the header
		send_packet(4'd3, 1, FILL_RANDOM);   // single-chunk packet
		send_packet(4'd8, 6, FILL_RANDOM);   // even ihl, full last header chunk

		for (int p = PH_STEADY; p <= PH_BACKPRESSURE; p++) begin
			case (phase_t'(p))
				PH_TX_IDLE: begin
					tx_idle_pct = 82;
					rx_stall_pct <= 0;
				end
				PH_RX_STALL: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 82;
				end
				PH_BOTH: begin
					tx_idle_pct = 27;
					rx_stall_pct <= 27;
				end
				PH_BACKPRESSURE: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
					hold_req <= 1'b1;
				end
				default: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
				end
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				pick = $urandom_range(99);
				ihl  = ($urandom_range(9) == 0) ? 4'($urandom_range(4))
				       : 4'($urandom_range(15, 5));
				hdr  = (int'((ihl < ihc_pkg::IHL_MIN) ? ihc_pkg::IHL_MIN : ihl) + 1) / 2;
				if (pick < 75)
					n = hdr + $urandom_range(4);
				else if (pick < 88)
					n = $urandom_range(hdr - 1, 1);
				else
					n = $urandom_range(3, 1);
				send_packet(ihl, n, FILL_RANDOM);
			end
		end
		s_tvalid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("ipv4_header_checksum_insert test passed");
		else
			$display("ipv4_header_checksum_insert test failed");
		$finish;
	end

endmodule
